// ===== rtl/core/dps_pkg.sv =====
// Shared types, sizes and codes for the dinner plate stack set.
// Used by dps_search, the top level and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dps_pkg;

    localparam int NUM_STACKS = 16;
    localparam int MAX_DEPTH  = 16;

    localparam int STACK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CNT_W    = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W   = $clog2(NUM_STACKS * MAX_DEPTH);
    localparam int DATA_W   = 32;
    localparam int CAP_W    = 5;
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int  REG_STACK_CAPACITY = 0;
    localparam int  APB_ADDR_W         = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_POP_AT = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } fsm_t;

    typedef logic [NUM_STACKS-1:0][CNT_W-1:0] fill_arr_t;

    typedef struct packed {
        logic               push_hit;
        logic [STACK_W-1:0] push_stack;
        logic               pop_hit;
        logic [STACK_W-1:0] pop_stack;
    } search_t;

    function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
        int c;
        c = int'(cap);
        if (c == 0) begin
            c = 1;
        end
        if (c > MAX_DEPTH) begin
            c = MAX_DEPTH;
        end
        return CNT_W'(c);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dps_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; holds the stacked values of the dinner plate stack set.
`timescale 1ns / 1ps
`default_nettype none

module dps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dps_search.sv =====
// Priority search over the per-stack fill counts.
// Finds the leftmost stack with room and the rightmost non-empty stack; uses dps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dps_search
    import dps_pkg::*;
(
    input  wire fill_arr_t        fill,
    input  wire logic [CNT_W-1:0] cap,
    output search_t               result
);

    always_comb begin
        result = '0;
        for (int s = NUM_STACKS - 1; s >= 0; s--) begin
            if (fill[s] < cap) begin
                result.push_hit   = 1'b1;
                result.push_stack = STACK_W'(s);
            end
        end
        for (int s = 0; s < NUM_STACKS; s++) begin
            if (fill[s] != '0) begin
                result.pop_hit   = 1'b1;
                result.pop_stack = STACK_W'(s);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dinner_plate_stack_set.sv =====
// Top level of the dinner plate stack set: command stream in, one result per command out.
// Uses dps_pkg, dps_search for stack selection and dps_ram for the stacked values.
`timescale 1ns / 1ps
`default_nettype none

// A row of NUM_STACKS stacks of 32-bit values, each holding up to stack_capacity entries.
// A push, or a pop that finds its target empty, loads its result straight into the
// output register; a successful pop first goes through S_READ, the registered read of
// the value memory. The block accepts one transaction at a time and takes the next one
// once the result is out or the output register is being drained. Fill counts live in
// flip-flops cleared by reset, so no clearing pass is needed. The capacity register is
// at byte address 0 and may only be written while no transaction is in flight.
module dinner_plate_stack_set
    import dps_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: push_value[31:0], stack_index[35:32], zero padding.
    input  wire logic [39:0]           s_tdata,
    // Fields from bit 0: cmd[1:0].
    input  wire logic [CMD_W-1:0]      s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0: popped value[31:0].
    output logic      [DATA_W-1:0]     m_tdata,
    // Fields from bit 0: status[1:0].
    output logic      [STATUS_W-1:0]   m_tuser
);

    logic [CAP_W-1:0]    cap_reg;
    fsm_t                state_reg, state_next;
    fill_arr_t           fill_reg, fill_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   out_value_reg, out_value_next;
    status_t             out_status_reg, out_status_next;

    logic [CNT_W-1:0]    eff_cap;
    search_t             found;
    logic                accept;
    logic                cfg_write;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic                load_now;
    status_t             load_status;
    logic                start_read;

    logic [DATA_W-1:0]   in_value;
    logic [IDX_W-1:0]    in_index;
    cmd_t                in_cmd;
    logic [STACK_W-1:0]  idx_stack;
    logic                idx_ok;
    logic [STACK_W-1:0]  pop_stack;

    assign in_value  = s_tdata[31:0];
    assign in_index  = s_tdata[35:32];
    assign in_cmd    = cmd_t'(s_tuser);
    assign idx_stack = STACK_W'(in_index);
    assign idx_ok    = (32'(in_index) < NUM_STACKS);

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1] == 1'(REG_STACK_CAPACITY));
    assign prdata    = (paddr[APB_ADDR_W-1] == 1'(REG_STACK_CAPACITY))
                       ? 32'(cap_reg) : 32'd0;

    assign eff_cap = eff_capacity(cap_reg);

    dps_search u_search (
        .fill   (fill_reg),
        .cap    (eff_cap),
        .result (found)
    );

    dps_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_STACKS * MAX_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        fill_next   = fill_reg;
        ram_we      = 1'b0;
        ram_waddr   = ADDR_W'(found.push_stack) * ADDR_W'(MAX_DEPTH)
                      + ADDR_W'(fill_reg[found.push_stack]);
        pop_stack   = found.pop_stack;
        load_now    = 1'b0;
        load_status = STAT_OK;
        start_read  = 1'b0;
        if (in_cmd == CMD_POP_AT) begin
            pop_stack = idx_stack;
        end
        ram_raddr = ADDR_W'(pop_stack) * ADDR_W'(MAX_DEPTH)
                    + ADDR_W'(fill_reg[pop_stack] - CNT_W'(1));
        if (accept) begin
            unique case (in_cmd)
                CMD_PUSH: begin
                    load_now = 1'b1;
                    if (found.push_hit) begin
                        ram_we = 1'b1;
                        fill_next[found.push_stack] = fill_reg[found.push_stack] + CNT_W'(1);
                    end else begin
                        load_status = STAT_FULL;
                    end
                end
                CMD_POP: begin
                    if (found.pop_hit) begin
                        start_read = 1'b1;
                        fill_next[pop_stack] = fill_reg[pop_stack] - CNT_W'(1);
                    end else begin
                        load_now    = 1'b1;
                        load_status = STAT_EMPTY;
                    end
                end
                CMD_POP_AT: begin
                    if (idx_ok && (fill_reg[pop_stack] != '0)) begin
                        start_read = 1'b1;
                        fill_next[pop_stack] = fill_reg[pop_stack] - CNT_W'(1);
                    end else begin
                        load_now    = 1'b1;
                        load_status = STAT_EMPTY;
                    end
                end
                default: begin
                    load_now = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start_read) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next    = m_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (state_reg == S_READ) begin
            m_valid_next    = 1'b1;
            out_value_next  = ram_rdata;
            out_status_next = STAT_OK;
        end else if (load_now) begin
            m_valid_next    = 1'b1;
            out_value_next  = '0;
            out_status_next = load_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_write) begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

    // The output register must be free whenever read data comes back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> !m_valid_reg)
        else $error("read data returned while the output register was occupied");

    // A push always produces its result in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_cmd == CMD_PUSH)) |=> m_valid_reg)
        else $error("push transaction produced no result");

    // A successful pop is followed by the memory read cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        start_read |=> (state_reg == S_READ) && !s_tready)
        else $error("pop did not enter the read cycle");

    // Memory writes happen only on accepted pushes with room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_IDLE) && found.push_hit && accept)
        else $error("unexpected memory write");

endmodule

`default_nettype wire

// ===== tb/sv/tb_dinner_plate_stack_set.sv =====
// Self-checking testbench for dinner_plate_stack_set: push, pop and pop-at transactions
// are checked against an in-bench model of the stacks. Depends on dps_pkg and the RTL.
`timescale 1ns / 1ps

module tb_dinner_plate_stack_set;
    import dps_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        cmd_t              cmd;
        logic [DATA_W-1:0] push_value;
        logic [IDX_W-1:0]  stack_index;
    } plate_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] taken_value;
        status_t           status;
    } plate_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata  = '0;
    logic [CMD_W-1:0]      s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    plate_cmd_t    pending_cmds[$];
    plate_result_t expected_results[$];
    plate_cmd_t    offered_cmd;

    logic [CAP_W-1:0]  capacity_model;
    logic [CNT_W-1:0]  fill_model [NUM_STACKS];
    logic [DATA_W-1:0] plate_model [NUM_STACKS][MAX_DEPTH];

    int  error_count    = 0;
    int  accepted_cmds  = 0;
    int  results_seen   = 0;
    int  pushes_dropped = 0;
    int  empty_pops     = 0;
    int  capacity_writes = 0;
    int  idle_cycles    = 0;
    int  gap_left       = 0;
    int  burst_left     = 0;
    int  hold_countdown = 0;
    int  pattern_mode   = 0;
    int  pattern_left   = 0;
    bit  sender_steady  = 1'b0;
    bit  receiver_steady = 1'b0;

    dinner_plate_stack_set DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic plate_result_t apply_plate_cmd(input plate_cmd_t c);
        plate_result_t r;
        int            cap_limit;
        bit            done;
        r.taken_value = '0;
        r.status      = STAT_OK;
        done          = 1'b0;
        cap_limit     = int'(capacity_model);
        if (cap_limit == 0) begin
            cap_limit = 1;
        end
        if (cap_limit > MAX_DEPTH) begin
            cap_limit = MAX_DEPTH;
        end
        case (c.cmd)
            CMD_PUSH: begin
                for (int s = 0; s < NUM_STACKS; s++) begin
                    if (!done && int'(fill_model[s]) < cap_limit) begin
                        plate_model[s][fill_model[s]] = c.push_value;
                        fill_model[s] = fill_model[s] + 1'b1;
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    r.status = STAT_FULL;
                    pushes_dropped++;
                end
            end
            CMD_POP: begin
                for (int s = NUM_STACKS - 1; s >= 0; s--) begin
                    if (!done && fill_model[s] != 0) begin
                        fill_model[s] = fill_model[s] - 1'b1;
                        r.taken_value = plate_model[s][fill_model[s]];
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    r.status = STAT_EMPTY;
                    empty_pops++;
                end
            end
            CMD_POP_AT: begin
                if (fill_model[c.stack_index] != 0) begin
                    fill_model[c.stack_index] = fill_model[c.stack_index] - 1'b1;
                    r.taken_value = plate_model[c.stack_index][fill_model[c.stack_index]];
                end else begin
                    r.status = STAT_EMPTY;
                    empty_pops++;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic plate_cmd_t random_plate_cmd(input int push_pct);
        plate_cmd_t c;
        if ($urandom_range(0, 99) < push_pct) begin
            c.cmd = CMD_PUSH;
        end else if ($urandom_range(0, 1) == 0) begin
            c.cmd = CMD_POP;
        end else begin
            c.cmd = CMD_POP_AT;
        end
        case ($urandom_range(0, 15))
            0: c.push_value = 32'h7FFF_FFFF;
            1: c.push_value = 32'h8000_0000;
            2: c.push_value = 32'h0000_0000;
            3: c.push_value = 32'hFFFF_FFFF;
            default: c.push_value = $urandom;
        endcase
        c.stack_index = IDX_W'($urandom_range(0, NUM_STACKS - 1));
        return c;
    endfunction

    task automatic queue_cmd(input cmd_t cmd, input logic [DATA_W-1:0] value,
                             input logic [IDX_W-1:0] index);
        plate_cmd_t c;
        c.cmd         = cmd;
        c.push_value  = value;
        c.stack_index = index;
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * REG_STACK_CAPACITY);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        capacity_model = value[CAP_W-1:0];
        capacity_writes++;
    endtask

    task automatic run_phase(input logic [31:0] cap_word, input int n_items,
                             input int push_pct);
        plate_cmd_t c;
        wait_drained();
        write_capacity(cap_word);
        for (int i = 0; i < n_items; i++) begin
            c = random_plate_cmd(push_pct);
            pending_cmds = {pending_cmds, c};
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results = {expected_results, apply_plate_cmd(offered_cmd)};
                accepted_cmds++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 && !sender_steady) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    offered_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= offered_cmd.cmd;
                    s_tdata  <= {4'b0, offered_cmd.stack_index, offered_cmd.push_value};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_countdown > 0) begin
            hold_countdown--;
            m_tready <= 1'b0;
        end else if (receiver_steady) begin
            m_tready <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                pattern_mode = $urandom_range(0, 3);
                pattern_left = $urandom_range(8, 64);
            end else begin
                pattern_left--;
            end
            case (pattern_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= pattern_left[2];
            endcase
        end
    end

    always @(posedge aclk) begin
        plate_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, value %h status %0d",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.taken_value) begin
                    $display("%0t: value mismatch, expected %h actual %h",
                             $time, want.taken_value, m_tdata);
                    error_count++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb_dinner_plate_stack_set failed");
            $finish;
        end
    end

    initial begin
        capacity_model = CAP_RESET;
        foreach (fill_model[s]) begin
            fill_model[s] = '0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty row, extreme values and pops at the reset capacity.
        queue_cmd(CMD_POP, 32'h0, 4'h0);
        queue_cmd(CMD_POP_AT, 32'h0, 4'hF);
        queue_cmd(CMD_POP_AT, 32'h0, 4'h0);
        queue_cmd(CMD_PUSH, 32'h7FFF_FFFF, 4'hF);
        queue_cmd(CMD_PUSH, 32'h8000_0000, 4'h0);
        queue_cmd(CMD_PUSH, 32'h0000_0000, 4'h5);
        queue_cmd(CMD_PUSH, 32'hAAAA_AAAA, 4'hA);
        queue_cmd(CMD_PUSH, 32'h5555_5555, 4'hF);
        queue_cmd(CMD_POP_AT, 32'hFFFF_FFFF, 4'h0);
        queue_cmd(CMD_POP, 32'h0, 4'h0);

        // Capacity zero acts as one; stack 0 now holds more than the limit.
        wait_drained();
        write_capacity(32'd0);
        for (int i = 0; i < NUM_STACKS - 1; i++) begin
            queue_cmd(CMD_PUSH, 32'hFFFF_FFFF - i, 4'(i));
        end
        queue_cmd(CMD_PUSH, 32'h1234_5678, 4'h0);
        queue_cmd(CMD_POP_AT, 32'h0, 4'hF);
        queue_cmd(CMD_POP, 32'h0, 4'h0);
        queue_cmd(CMD_POP_AT, 32'h0, 4'h0);

        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        run_phase(32'd31, 90, 70);
        wait_drained();
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        run_phase(32'd1, 80, 60);
        run_phase(32'd3, 80, 75);
        run_phase(32'd16, 80, 35);
        hold_countdown = LONG_HOLD;
        run_phase(32'd2, 80, 80);
        run_phase(32'($urandom_range(1, 16)), 80, 50);
        sender_steady = 1'b1;
        run_phase(32'd0, 60, 50);
        wait_drained();
        sender_steady = 1'b0;
        run_phase(32'd8, 90, 30);
        wait_drained();

        $display("Ran %0d commands over %0d capacity settings, %0d results checked.",
                 accepted_cmds, capacity_writes, results_seen);
        $display("Pushes dropped on a full row: %0d, pops of an empty target: %0d.",
                 pushes_dropped, empty_pops);
        if (error_count == 0) begin
            $display("tb_dinner_plate_stack_set passed");
        end else begin
            $display("tb_dinner_plate_stack_set failed");
        end
        $finish;
    end

endmodule
